// ----- rtl/core/tftp_pkg.sv -----
// ----------------------------------------------------------------------------
// tftp_pkg: shared types and codes for the TFTP client transfer controller
// Event, packet, send and phase codes, and the structs passed between blocks.
// ----------------------------------------------------------------------------
package tftp_pkg;

   localparam int unsigned ADDR_W = 3;
   localparam int unsigned DATA_W = 32;

   // register indexes on the configuration port
   typedef enum logic [0:0] {
      REG_MODE       = 1'b0,
      REG_BLOCK_SIZE = 1'b1
   } reg_type;

   localparam logic [15:0] BLOCK_SIZE_RESET = 16'd512;

   typedef enum logic [2:0] {
      OP_START     = 3'd0,
      OP_PACKET    = 3'd1,
      OP_TIMEOUT   = 3'd2,
      OP_RECV_FAIL = 3'd3,
      OP_MALFORMED = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      PKT_DATA  = 2'd0,
      PKT_ACK   = 2'd1,
      PKT_ERROR = 2'd2,
      PKT_OTHER = 2'd3
   } pkt_type;

   typedef enum logic [2:0] {
      SEND_NONE = 3'd0,
      SEND_RRQ  = 3'd1,
      SEND_WRQ  = 3'd2,
      SEND_DATA = 3'd3,
      SEND_ACK  = 3'd4,
      SEND_ERR  = 3'd5
   } send_type;

   localparam logic [2:0] ERR_UNDEF   = 3'd0;
   localparam logic [2:0] ERR_ILLEGAL = 3'd4;
   localparam logic [2:0] ERR_TID     = 3'd5;

   localparam logic [2:0] PHASE_IDLE  = 3'd0;
   localparam logic [2:0] PHASE_AWAIT = 3'd1;
   localparam logic [2:0] PHASE_XFER  = 3'd2;
   localparam logic [2:0] PHASE_DONE  = 3'd3;
   localparam logic [2:0] PHASE_FAIL  = 3'd4;

   typedef struct packed {
      logic        mode;
      logic [15:0] block_size;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [1:0]  packet_kind;
      logic [15:0] block_number;
      logic [15:0] payload_length;
      logic [31:0] source_addr;
      logic [15:0] source_port;
      logic [15:0] fill_length;
   } item_type;

   typedef struct packed {
      logic [2:0]  send_kind;
      logic [15:0] send_block;
      logic [15:0] send_length;
      logic [2:0]  error_code;
      logic        store_payload;
      logic        fetch_next;
      logic [2:0]  phase;
   } result_type;

endpackage

// ----- rtl/core/tftp_client_transfer_fsm.sv -----
// ----------------------------------------------------------------------------
// tftp_client_transfer_fsm: TFTP client transfer controller
// Takes one protocol event at a time and returns the packet to send.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event (start, received packet, timeout, receive
//   failure, malformed packet) with the packet's fields; rsp_* carries
//   exactly one result per event: what to send, store/fetch strobes and
//   the phase after the event. Both use valid/ready.
//   Configure mode and block_size over the APB-style port while idle.
//   The input register loads at the req transfer and the result register
//   loads from it when the event advances, which raises rsp_valid.
//   Throughput: one event per cycle while the receiver takes results;
//   the logic between the two registers is compares and a 16-bit increment.
//   When the receiver stalls, the result register holds, the input
//   register fills, and req_ready falls only once both are occupied.
//   Reset empties both registers, returns to the idle phase with expected
//   block one, and loads mode download and block size 512.
// ----------------------------------------------------------------------------
module tftp_client_transfer_fsm import tftp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_operation,
   input  logic [1:0]        req_packet_kind,
   input  logic [15:0]       req_block_number,
   input  logic [15:0]       req_payload_length,
   input  logic [31:0]       req_source_addr,
   input  logic [15:0]       req_source_port,
   input  logic [15:0]       req_fill_length,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_send_kind,
   output logic [15:0]       rsp_send_block,
   output logic [15:0]       rsp_send_length,
   output logic [2:0]        rsp_error_code,
   output logic              rsp_store_payload,
   output logic              rsp_fetch_next,
   output logic [2:0]        rsp_phase,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;

   tftp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tftp_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // advance when the result register is free or being drained
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.operation      <= req_operation;
         item_ff.packet_kind    <= req_packet_kind;
         item_ff.block_number   <= req_block_number;
         item_ff.payload_length <= req_payload_length;
         item_ff.source_addr    <= req_source_addr;
         item_ff.source_port    <= req_source_port;
         item_ff.fill_length    <= req_fill_length;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_kind     = rsp_ff.send_kind;
   assign rsp_send_block    = rsp_ff.send_block;
   assign rsp_send_length   = rsp_ff.send_length;
   assign rsp_error_code    = rsp_ff.error_code;
   assign rsp_store_payload = rsp_ff.store_payload;
   assign rsp_fetch_next    = rsp_ff.fetch_next;
   assign rsp_phase         = rsp_ff.phase;

`ifndef SYNTHESIS
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed event left no result");

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !advance) |=> (item_valid_ff && $stable(item_ff)))
      else $error("held event lost while output stalled");

   a_error_code_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_code != ERR_UNDEF) |-> rsp_send_kind == SEND_ERR)
      else $error("error code without error packet");

   a_store_is_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_store_payload) |->
         (rsp_send_kind == SEND_ACK && rsp_phase != PHASE_FAIL))
      else $error("payload stored without acknowledgement");

   a_fetch_is_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fetch_next) |->
         (rsp_send_kind == SEND_DATA && rsp_phase == PHASE_XFER))
      else $error("block fetched without data packet");
`endif

endmodule

// ----- rtl/core/tftp_csr.sv -----
// ----------------------------------------------------------------------------
// tftp_csr: configuration registers
// APB-style slave holding the transfer direction and the block size.
// ----------------------------------------------------------------------------
module tftp_csr import tftp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic        mode_ff;
   logic [15:0] block_size_ff;
   logic        wr_en;
   reg_type     reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = reg_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         block_size_ff <= BLOCK_SIZE_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_MODE:       mode_ff       <= pwdata[0];
            REG_BLOCK_SIZE: block_size_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MODE:       prdata = {{(DATA_W-1){1'b0}}, mode_ff};
         REG_BLOCK_SIZE: prdata = {{(DATA_W-16){1'b0}}, block_size_ff};
         default:        prdata = '0;
      endcase
   end

   assign cfg.mode       = mode_ff;
   assign cfg.block_size = block_size_ff;

endmodule

// ----- rtl/core/tftp_engine.sv -----
// ----------------------------------------------------------------------------
// tftp_engine: transfer state and per-event decision logic
// Holds phase, expected block, peer identity and the last data sent, and
// works out the reply to one event combinationally.
// ----------------------------------------------------------------------------
module tftp_engine import tftp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic [2:0]  phase_ff,     phase_in;
   logic [15:0] expected_ff,  expected_in;
   logic [31:0] peer_addr_ff, peer_addr_in;
   logic [15:0] peer_port_ff, peer_port_in;
   logic        sent_data_ff, sent_data_in;
   logic [15:0] sent_len_ff,  sent_len_in;

   logic        active;
   logic        foreign;
   logic [15:0] expected_inc;
   logic [15:0] up_len;

   assign active       = (phase_ff == PHASE_AWAIT) || (phase_ff == PHASE_XFER);
   // the first reply latches the peer, so it can never look foreign
   assign foreign      = (phase_ff == PHASE_XFER) &&
                         ((item.source_addr != peer_addr_ff) ||
                          (item.source_port != peer_port_ff));
   assign expected_inc = expected_ff + 16'd1;
   assign up_len       = (item.fill_length < cfg.block_size) ? item.fill_length
                                                             : cfg.block_size;

   always_comb begin
      phase_in     = phase_ff;
      expected_in  = expected_ff;
      peer_addr_in = peer_addr_ff;
      peer_port_in = peer_port_ff;
      sent_data_in = sent_data_ff;
      sent_len_in  = sent_len_ff;
      result       = '0;
      result.send_kind = SEND_NONE;

      if (item.operation == OP_START) begin
         phase_in         = PHASE_AWAIT;
         sent_data_in     = 1'b0;
         sent_len_in      = '0;
         expected_in      = cfg.mode ? 16'd0 : 16'd1;
         result.send_kind = cfg.mode ? SEND_WRQ : SEND_RRQ;
      end else if (active) begin
         case (item.operation)
            OP_TIMEOUT, OP_RECV_FAIL: begin
               phase_in          = PHASE_FAIL;
               result.send_kind  = SEND_ERR;
               result.error_code = ERR_UNDEF;
            end
            OP_MALFORMED: begin
               phase_in          = PHASE_FAIL;
               result.send_kind  = SEND_ERR;
               result.error_code = ERR_ILLEGAL;
            end
            OP_PACKET: begin
               if (phase_ff == PHASE_AWAIT) begin
                  peer_addr_in = item.source_addr;
                  peer_port_in = item.source_port;
                  phase_in     = PHASE_XFER;
               end
               if (foreign) begin
                  phase_in          = PHASE_FAIL;
                  result.send_kind  = SEND_ERR;
                  result.error_code = ERR_TID;
               end else if (item.packet_kind == PKT_ERROR) begin
                  // peer gave up: fail quietly
                  phase_in = PHASE_FAIL;
               end else if (!cfg.mode) begin
                  if ((item.packet_kind != PKT_DATA) ||
                      (item.block_number > expected_ff)) begin
                     phase_in          = PHASE_FAIL;
                     result.send_kind  = SEND_ERR;
                     result.error_code = ERR_ILLEGAL;
                  end else if (item.block_number == expected_ff) begin
                     if (item.payload_length < cfg.block_size) begin
                        phase_in = PHASE_DONE;
                     end
                     expected_in          = expected_inc;
                     result.send_kind     = SEND_ACK;
                     result.send_block    = item.block_number;
                     result.store_payload = 1'b1;
                  end else begin
                     // duplicate: re-acknowledge the previous block
                     result.send_kind  = SEND_ACK;
                     result.send_block = expected_ff - 16'd1;
                  end
               end else begin
                  if ((item.packet_kind != PKT_ACK) ||
                      (item.block_number > expected_ff)) begin
                     phase_in          = PHASE_FAIL;
                     result.send_kind  = SEND_ERR;
                     result.error_code = ERR_ILLEGAL;
                  end else if (item.block_number == expected_ff) begin
                     if (sent_data_ff && (sent_len_ff < cfg.block_size)) begin
                        phase_in = PHASE_DONE;
                     end else begin
                        expected_in        = expected_inc;
                        sent_data_in       = 1'b1;
                        sent_len_in        = up_len;
                        result.send_kind   = SEND_DATA;
                        result.send_block  = expected_inc;
                        result.send_length = up_len;
                        result.fetch_next  = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      result.phase = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         expected_ff  <= 16'd1;
         peer_addr_ff <= '0;
         peer_port_ff <= '0;
         sent_data_ff <= 1'b0;
         sent_len_ff  <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         expected_ff  <= expected_in;
         peer_addr_ff <= peer_addr_in;
         peer_port_ff <= peer_port_in;
         sent_data_ff <= sent_data_in;
         sent_len_ff  <= sent_len_in;
      end
   end

endmodule

// ----- bench/tb_tftp_client_transfer_fsm.sv -----
// ----------------------------------------------------------------------------
// tb_tftp_client_transfer_fsm: self-checking bench for the TFTP client FSM
// Drives protocol events over req_*, predicts each rsp_* result from an
// in-bench model of the client state, and checks it field by field. Covers
// register access, download and upload transfers, every failure path, a
// back-to-back run of blocks, back-pressure, and randomised transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tftp_client_transfer_fsm;
   import tftp_pkg::*;

   localparam int          RANDOM_ITEMS   = 350;
   localparam int          RUN_BLOCKS     = 48;
   localparam int          HOLD_CYCLES    = 60;
   localparam int          DRAIN_CYCLES   = 6;
   localparam logic [15:0] MIN_BLOCK      = 16'd8;
   localparam logic [15:0] MAX_BLOCK      = 16'd65464;
   localparam logic        MODE_DOWNLOAD  = 1'b0;
   localparam logic        MODE_UPLOAD    = 1'b1;
   localparam logic [2:0]  OP_FIRST_SPARE = 3'd5;
   localparam logic [2:0]  OP_LAST_SPARE  = 3'd7;
   localparam logic [ADDR_W-1:0] ADDR_MODE       = {REG_MODE, 2'b00};
   localparam logic [ADDR_W-1:0] ADDR_BLOCK_SIZE = {REG_BLOCK_SIZE, 2'b00};

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [2:0]        req_operation;
   logic [1:0]        req_packet_kind;
   logic [15:0]       req_block_number;
   logic [15:0]       req_payload_length;
   logic [31:0]       req_source_addr;
   logic [15:0]       req_source_port;
   logic [15:0]       req_fill_length;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [2:0]        rsp_send_kind;
   logic [15:0]       rsp_send_block;
   logic [15:0]       rsp_send_length;
   logic [2:0]        rsp_error_code;
   logic              rsp_store_payload;
   logic              rsp_fetch_next;
   logic [2:0]        rsp_phase;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // client state as the bench sees it
   logic        cfg_mode;
   logic [15:0] cfg_block_size;
   logic [2:0]  st_phase;
   logic [15:0] st_expected_block;
   logic [31:0] st_peer_addr;
   logic [15:0] st_peer_port;
   logic        st_last_was_data;
   logic [15:0] st_last_length;

   result_type  expected_replies[$];
   int          mismatch_count;
   bit          stall_enable;
   bit          hold_request;
   int          hold_left;
   int          stall_tick;
   logic [31:0] server_addr;
   logic [15:0] server_port;

   tftp_client_transfer_fsm DUT (.*);

   initial clock = 1'b0;
   always #2 clock = ~clock;

   initial begin
      #4_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------- model
   task automatic advance_client(input item_type ev, output result_type r);
      logic        fail_now;
      logic        send_error;
      logic [2:0]  code;
      logic [15:0] len;
      r          = '0;
      fail_now   = 1'b0;
      send_error = 1'b1;
      code       = ERR_UNDEF;
      if (ev.operation == OP_START) begin
         st_phase          = PHASE_AWAIT;
         st_last_was_data  = 1'b0;
         st_last_length    = 16'd0;
         st_expected_block = (cfg_mode == MODE_UPLOAD) ? 16'd0 : 16'd1;
         r.send_kind       = (cfg_mode == MODE_UPLOAD) ? SEND_WRQ : SEND_RRQ;
      end else if (st_phase != PHASE_AWAIT && st_phase != PHASE_XFER) begin
         // outside a transfer: drop the event
      end else if (ev.operation == OP_TIMEOUT || ev.operation == OP_RECV_FAIL) begin
         fail_now = 1'b1;
      end else if (ev.operation == OP_MALFORMED) begin
         fail_now = 1'b1;
         code     = ERR_ILLEGAL;
      end else if (ev.operation == OP_PACKET) begin
         // first reply fixes the peer
         if (st_phase == PHASE_AWAIT) begin
            st_peer_addr = ev.source_addr;
            st_peer_port = ev.source_port;
            st_phase     = PHASE_XFER;
         end
         if (ev.source_addr != st_peer_addr || ev.source_port != st_peer_port) begin
            fail_now = 1'b1;
            code     = ERR_TID;
         end else if (ev.packet_kind == PKT_ERROR) begin
            fail_now   = 1'b1;
            send_error = 1'b0;
         end else if (cfg_mode == MODE_DOWNLOAD) begin
            if (ev.packet_kind != PKT_DATA || ev.block_number > st_expected_block) begin
               fail_now = 1'b1;
               code     = ERR_ILLEGAL;
            end else if (ev.block_number == st_expected_block) begin
               if (ev.payload_length < cfg_block_size) st_phase = PHASE_DONE;
               st_expected_block = st_expected_block + 16'd1;
               r.send_kind       = SEND_ACK;
               r.send_block      = ev.block_number;
               r.store_payload   = 1'b1;
            end else begin
               r.send_kind  = SEND_ACK;
               r.send_block = st_expected_block - 16'd1;
            end
         end else begin
            if (ev.packet_kind != PKT_ACK || ev.block_number > st_expected_block) begin
               fail_now = 1'b1;
               code     = ERR_ILLEGAL;
            end else if (ev.block_number == st_expected_block) begin
               if (st_last_was_data && st_last_length < cfg_block_size) begin
                  st_phase = PHASE_DONE;
               end else begin
                  len = (ev.fill_length < cfg_block_size) ? ev.fill_length
                                                          : cfg_block_size;
                  st_expected_block = st_expected_block + 16'd1;
                  st_last_was_data  = 1'b1;
                  st_last_length    = len;
                  r.send_kind       = SEND_DATA;
                  r.send_block      = st_expected_block;
                  r.send_length     = len;
                  r.fetch_next      = 1'b1;
               end
            end
         end
      end
      if (fail_now) begin
         st_phase     = PHASE_FAIL;
         r.send_kind  = send_error ? SEND_ERR : SEND_NONE;
         r.error_code = send_error ? code : ERR_UNDEF;
      end
      r.phase = st_phase;
   endtask

   // ------------------------------------------------------------- checking
   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected %0d, got %0d", what, want, got);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_replies.size() == 0) begin
            note_mismatch("result with nothing outstanding, send_kind", 32'd0,
                          32'(rsp_send_kind));
         end else begin
            want = expected_replies.pop_front();
            if (rsp_send_kind !== want.send_kind)
               note_mismatch("send_kind", 32'(want.send_kind), 32'(rsp_send_kind));
            if (rsp_send_block !== want.send_block)
               note_mismatch("send_block", 32'(want.send_block), 32'(rsp_send_block));
            if (rsp_send_length !== want.send_length)
               note_mismatch("send_length", 32'(want.send_length), 32'(rsp_send_length));
            if (rsp_error_code !== want.error_code)
               note_mismatch("error_code", 32'(want.error_code), 32'(rsp_error_code));
            if (rsp_store_payload !== want.store_payload)
               note_mismatch("store_payload", 32'(want.store_payload),
                             32'(rsp_store_payload));
            if (rsp_fetch_next !== want.fetch_next)
               note_mismatch("fetch_next", 32'(want.fetch_next), 32'(rsp_fetch_next));
            if (rsp_phase !== want.phase)
               note_mismatch("phase", 32'(want.phase), 32'(rsp_phase));
         end
      end
   end

   // receiver: random stalls in alternating stretches, plus a long hold on request
   initial begin
      rsp_ready  = 1'b0;
      hold_left  = 0;
      stall_tick = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         stall_tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!stall_enable || ((stall_tick / 48) % 2) == 1) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 2) != 0);
         end
      end
   end

   // ------------------------------------------------------------- driving
   function automatic item_type make_item(logic [2:0] op, logic [1:0] kind,
                                          logic [15:0] blk, logic [15:0] plen,
                                          logic [31:0] addr, logic [15:0] port,
                                          logic [15:0] fill);
      item_type ev;
      ev.operation      = op;
      ev.packet_kind    = kind;
      ev.block_number   = blk;
      ev.payload_length = plen;
      ev.source_addr    = addr;
      ev.source_port    = port;
      ev.fill_length    = fill;
      return ev;
   endfunction

   function automatic item_type random_item();
      return make_item(OP_PACKET, 2'($urandom()), 16'($urandom()), 16'($urandom()),
                       $urandom(), 16'($urandom()), 16'($urandom()));
   endfunction

   task automatic send_event(input item_type ev);
      result_type r;
      @(negedge clock);
      req_valid          <= 1'b1;
      req_operation      <= ev.operation;
      req_packet_kind    <= ev.packet_kind;
      req_block_number   <= ev.block_number;
      req_payload_length <= ev.payload_length;
      req_source_addr    <= ev.source_addr;
      req_source_port    <= ev.source_port;
      req_fill_length    <= ev.fill_length;
      do @(posedge clock); while (!req_ready);
      advance_client(ev, r);
      expected_replies.push_back(r);
   endtask

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_MODE) cfg_mode = data[0];
      else if (addr == ADDR_BLOCK_SIZE) cfg_block_size = data[15:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_read(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] want);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) note_mismatch("register read", want, prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic configure(input logic mode, input logic [15:0] block_size);
      wait_drained();
      csr_write(ADDR_MODE, {{(DATA_W-1){1'b0}}, mode});
      csr_write(ADDR_BLOCK_SIZE, {{(DATA_W-16){1'b0}}, block_size});
   endtask

   // --------------------------------------------------------------- tests
   task automatic test_register_access();
      csr_read(ADDR_MODE, {{(DATA_W-1){1'b0}}, MODE_DOWNLOAD});
      csr_read(ADDR_BLOCK_SIZE, {{(DATA_W-16){1'b0}}, BLOCK_SIZE_RESET});
      csr_write(ADDR_MODE, {{(DATA_W-1){1'b0}}, MODE_UPLOAD});
      csr_write(ADDR_BLOCK_SIZE, {{(DATA_W-16){1'b0}}, MAX_BLOCK});
      csr_read(ADDR_MODE, {{(DATA_W-1){1'b0}}, MODE_UPLOAD});
      csr_read(ADDR_BLOCK_SIZE, {{(DATA_W-16){1'b0}}, MAX_BLOCK});
   endtask

   task automatic test_download_transfer();
      logic [31:0] a;
      logic [15:0] p;
      a = 32'hC0A8_0A45;
      p = 16'd1069;
      configure(MODE_DOWNLOAD, MIN_BLOCK);
      send_event(make_item(OP_PACKET, PKT_DATA, 16'd1, MIN_BLOCK, a, p, 16'd0));
      send_event(make_item(OP_START, PKT_DATA, 16'd0, 16'd0, 32'd0, 16'd0, 16'd0));
      // first reply is a duplicate of block zero
      send_event(make_item(OP_PACKET, PKT_DATA, 16'd0, 16'd0, a, p, 16'hFFFF));
      send_event(make_item(OP_PACKET, PKT_DATA, 16'd1, MIN_BLOCK, a, p, 16'd0));
      send_event(make_item(OP_PACKET, PKT_DATA, 16'd1, MIN_BLOCK, a, p, 16'd0));
      send_event(make_item(OP_LAST_SPARE, PKT_DATA, 16'd2, MIN_BLOCK, a, p, 16'd0));
      send_event(make_item(OP_PACKET, PKT_DATA, 16'd2, 16'hFFFF, a, p, 16'd0));
      send_event(make_item(OP_PACKET, PKT_DATA, 16'd3, MIN_BLOCK - 16'd1, a, p, 16'd0));
      send_event(make_item(OP_TIMEOUT, PKT_DATA, 16'd4, 16'd0, a, p, 16'd0));
   endtask

   task automatic test_upload_transfer();
      logic [31:0] a;
      logic [15:0] p;
      a = 32'hFFFF_FFFF;
      p = 16'hFFFF;
      configure(MODE_UPLOAD, MAX_BLOCK);
      send_event(make_item(OP_START, PKT_ACK, 16'd0, 16'd0, 32'd0, 16'd0, 16'd0));
      // fill above the block size is cut down
      send_event(make_item(OP_PACKET, PKT_ACK, 16'd0, 16'd0, a, p, 16'hFFFF));
      send_event(make_item(OP_PACKET, PKT_ACK, 16'd0, 16'd0, a, p, 16'd3));
      send_event(make_item(OP_PACKET, PKT_ACK, 16'd1, 16'hFFFF, a, p, 16'd100));
      send_event(make_item(OP_PACKET, PKT_ACK, 16'd2, 16'd0, a, p, 16'd0));
   endtask

   task automatic test_failure_paths();
      logic [31:0] a;
      logic [15:0] p;
      a = 32'h0A00_0002;
      p = 16'd4000;
      configure(MODE_DOWNLOAD, BLOCK_SIZE_RESET);
      send_event(make_item(OP_START, PKT_DATA, 16'd0, 16'd0, a, p, 16'd0));
      send_event(make_item(OP_PACKET, PKT_DATA, 16'hFFFF, 16'd0, 32'd0, 16'd0, 16'd0));
      // foreign source is caught before the packet kind
      send_event(make_item(OP_START, PKT_DATA, 16'd0, 16'd0, a, p, 16'd0));
      send_event(make_item(OP_PACKET, PKT_DATA, 16'd1, BLOCK_SIZE_RESET, a, p, 16'd0));
      send_event(make_item(OP_PACKET, PKT_ERROR, 16'd2, 16'd0, a ^ 32'h1, p, 16'd0));
      send_event(make_item(OP_START, PKT_DATA, 16'd0, 16'd0, a, p, 16'd0));
      send_event(make_item(OP_PACKET, PKT_ERROR, 16'd0, 16'd0, a, p, 16'd0));
      send_event(make_item(OP_START, PKT_DATA, 16'd0, 16'd0, a, p, 16'd0));
      send_event(make_item(OP_TIMEOUT, PKT_DATA, 16'd0, 16'd0, a, p, 16'd0));
      send_event(make_item(OP_START, PKT_DATA, 16'd0, 16'd0, a, p, 16'd0));
      send_event(make_item(OP_RECV_FAIL, PKT_DATA, 16'd0, 16'd0, a, p, 16'd0));
      send_event(make_item(OP_START, PKT_DATA, 16'd0, 16'd0, a, p, 16'd0));
      send_event(make_item(OP_MALFORMED, PKT_DATA, 16'd0, 16'd0, a, p, 16'd0));
      send_event(make_item(OP_START, PKT_DATA, 16'd0, 16'd0, a, p, 16'd0));
      send_event(make_item(OP_PACKET, PKT_OTHER, 16'd1, 16'd0, a, p, 16'd0));
   endtask

   // run in-order blocks back to back with the receiver always ready
   task automatic test_block_run();
      int          n;
      logic [31:0] a;
      logic [15:0] p;
      a = $urandom();
      p = 16'($urandom());
      configure(MODE_DOWNLOAD, MIN_BLOCK);
      stall_enable = 1'b0;
      send_event(make_item(OP_START, PKT_DATA, 16'd0, 16'd0, a, p, 16'd0));
      for (n = 0; n < RUN_BLOCKS; n++)
         send_event(make_item(OP_PACKET, PKT_DATA, st_expected_block, MIN_BLOCK,
                              a, p, 16'($urandom())));
      send_event(make_item(OP_PACKET, PKT_DATA, st_expected_block, 16'd0, a, p, 16'd0));
      wait_drained();
      stall_enable = 1'b1;
   endtask

   task automatic test_backpressure();
      int          n;
      logic [31:0] a;
      logic [15:0] p;
      a = $urandom();
      p = 16'($urandom());
      configure(MODE_UPLOAD, 16'd16);
      send_event(make_item(OP_START, PKT_ACK, 16'd0, 16'd0, a, p, 16'd0));
      hold_request = 1'b1;
      for (n = 0; n < 24; n++)
         send_event(make_item(OP_PACKET, PKT_ACK, st_expected_block, 16'($urandom()),
                              a, p, 16'($urandom_range(16, 65535))));
   endtask

   // well-formed next packet of the running transfer, random content elsewhere
   function automatic item_type next_packet();
      item_type ev;
      bit       short_block;
      ev             = random_item();
      ev.source_addr = server_addr;
      ev.source_port = server_port;
      ev.block_number = st_expected_block;
      short_block    = ($urandom_range(0, 7) == 0);
      if (cfg_mode == MODE_DOWNLOAD) begin
         ev.packet_kind    = PKT_DATA;
         ev.payload_length = short_block ? 16'($urandom_range(0, cfg_block_size - 1))
                                         : 16'($urandom_range(cfg_block_size, 65535));
      end else begin
         ev.packet_kind = PKT_ACK;
         ev.fill_length = short_block ? 16'($urandom_range(0, cfg_block_size - 1))
                                      : 16'($urandom_range(cfg_block_size, 65535));
      end
      return ev;
   endfunction

   function automatic item_type stray_event();
      item_type ev;
      ev = next_packet();
      case ($urandom_range(0, 9))
         0: ev.block_number = st_expected_block - 16'd1 - 16'($urandom_range(0, 3));
         1: ev.block_number = st_expected_block + 16'd1 + 16'($urandom_range(0, 1000));
         2: begin
            if ($urandom_range(0, 1)) ev.source_addr[$urandom_range(0, 31)] ^= 1'b1;
            else ev.source_port[$urandom_range(0, 15)] ^= 1'b1;
         end
         3: ev.operation = OP_TIMEOUT;
         4: ev.operation = OP_RECV_FAIL;
         5: ev.operation = OP_MALFORMED;
         6: ev.packet_kind = PKT_ERROR;
         7: ev.packet_kind = (cfg_mode == MODE_DOWNLOAD) ?
                             ($urandom_range(0, 1) ? PKT_ACK : PKT_OTHER) :
                             ($urandom_range(0, 1) ? PKT_DATA : PKT_OTHER);
         8: ev.operation = 3'($urandom_range(OP_FIRST_SPARE, OP_LAST_SPARE));
         default: ev.operation = OP_START;
      endcase
      return ev;
   endfunction

   task automatic test_random_transfers();
      int          active_items;
      int          budget;
      int          burst_left;
      int          n;
      bit          gaps_on;
      logic [15:0] bs;
      item_type    ev;
      active_items = 0;
      burst_left   = 8;
      while (active_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       bs = MIN_BLOCK;
            1:       bs = MAX_BLOCK;
            2:       bs = BLOCK_SIZE_RESET;
            5:       bs = 16'($urandom_range(MIN_BLOCK, MAX_BLOCK));
            default: bs = 16'($urandom_range(MIN_BLOCK, 64));
         endcase
         configure(1'($urandom_range(0, 1)), bs);
         gaps_on     = ($urandom_range(0, 3) != 0);
         server_addr = $urandom();
         server_port = 16'($urandom());
         budget      = $urandom_range(4, 40);
         for (n = 0; n < budget; n++) begin
            if (n == 0) begin
               ev = ($urandom_range(0, 9) == 0) ? random_item()
                    : make_item(OP_START, 2'($urandom()), 16'($urandom()), 16'($urandom()),
                                $urandom(), 16'($urandom()), 16'($urandom()));
            end else if (st_phase == PHASE_DONE || st_phase == PHASE_FAIL) begin
               if ($urandom_range(0, 3) != 0) break;
               ev = random_item();
               budget = n + 1;
            end else begin
               ev = ($urandom_range(0, 9) < 8) ? next_packet() : stray_event();
            end
            if (ev.operation <= OP_MALFORMED &&
                (ev.operation == OP_START || st_phase == PHASE_AWAIT ||
                 st_phase == PHASE_XFER))
               active_items++;
            send_event(ev);
            if (gaps_on) begin
               burst_left--;
               if (burst_left <= 0) begin
                  idle_sender($urandom_range(1, 5));
                  burst_left = $urandom_range(1, 16);
               end
            end
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_operation      = OP_START;
      req_packet_kind    = PKT_DATA;
      req_block_number   = 16'd0;
      req_payload_length = 16'd0;
      req_source_addr    = 32'd0;
      req_source_port    = 16'd0;
      req_fill_length    = 16'd0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      cfg_mode           = MODE_DOWNLOAD;
      cfg_block_size     = BLOCK_SIZE_RESET;
      st_phase           = PHASE_IDLE;
      st_expected_block  = 16'd1;
      st_peer_addr       = 32'd0;
      st_peer_port       = 16'd0;
      st_last_was_data   = 1'b0;
      st_last_length     = 16'd0;
      mismatch_count     = 0;
      stall_enable       = 1'b1;
      hold_request       = 1'b0;
      server_addr        = 32'd0;
      server_port        = 16'd0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_access();
      test_download_transfer();
      test_upload_transfer();
      test_failure_paths();
      test_block_run();
      test_backpressure();
      test_random_transfers();
      wait_drained();

      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/tftp_pkg.sv
rtl/core/tftp_csr.sv
rtl/core/tftp_engine.sv
rtl/core/tftp_client_transfer_fsm.sv
bench/tb_tftp_client_transfer_fsm.sv
